[hdl/ezr_pkg.sv]
// Shared types, fixed-point constants and helper functions for the Euler-to-matrix block.
// No dependencies; used by ezr_sincos and euler_zyx_to_rotation_matrix_top.
package ezr_pkg;

	localparam int ANGLE_W = 16;
	localparam int FRAC_W  = ANGLE_W - 3;
	localparam int ZW      = 46;
	localparam int XW      = 34;
	localparam int PW      = 2 * XW;
	localparam int OUT_W   = 16;
	localparam int MAX_STAGES = 32;

	localparam logic signed [63:0] FIVE_POW_12   = 64'sd244140625;
	localparam logic signed [ZW-1:0] PI_PICO      = 46'sd3141592653590;
	localparam logic signed [ZW-1:0] HALF_PI_PICO = 46'sd1570796326795;
	localparam logic signed [XW-1:0] CORDIC_GAIN  = 34'sd652032874;

	localparam logic signed [ZW-1:0] ATAN_PICO [0:MAX_STAGES-1] = '{
		46'sd785398163397, 46'sd463647609001, 46'sd244978663127, 46'sd124354994547,
		46'sd62418809996, 46'sd31239833430, 46'sd15623728620, 46'sd7812341060,
		46'sd3906230132, 46'sd1953122516, 46'sd976562190, 46'sd488281211,
		46'sd244140620, 46'sd122070312, 46'sd61035156, 46'sd30517578,
		46'sd15258789, 46'sd7629395, 46'sd3814697, 46'sd1907349,
		46'sd953674, 46'sd476837, 46'sd238419, 46'sd119209,
		46'sd59605, 46'sd29802, 46'sd14901, 46'sd7451,
		46'sd3725, 46'sd1863, 46'sd931, 46'sd466
	};

	localparam logic paddr_order = 1'b0;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] angle_first;
		logic signed [ANGLE_W-1:0] angle_second;
		logic signed [ANGLE_W-1:0] angle_third;
	} angles_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] m00;
		logic signed [OUT_W-1:0] m01;
		logic signed [OUT_W-1:0] m02;
		logic signed [OUT_W-1:0] m10;
		logic signed [OUT_W-1:0] m11;
		logic signed [OUT_W-1:0] m12;
		logic signed [OUT_W-1:0] m20;
		logic signed [OUT_W-1:0] m21;
		logic signed [OUT_W-1:0] m22;
	} matrix_t;

	// Q60 product to Q30 with round half up
	function automatic logic signed [XW-1:0] round_q30(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		t = p + (PW'(1) <<< 29);
		t = t >>> 30;
		return t[XW-1:0];
	endfunction

	// Q60 to saturated Q1.14
	function automatic logic signed [OUT_W-1:0] entry_q14(input logic signed [PW-1:0] q);
		logic signed [PW-1:0] t;
		t = q + (PW'(1) <<< 45);
		t = t >>> 46;
		if (t > PW'(16384))
			t = PW'(16384);
		if (t < -PW'(16384))
			t = -PW'(16384);
		return t[OUT_W-1:0];
	endfunction

endpackage

[hdl/ezr_sincos.sv]
// Pipelined rotation-mode CORDIC: angle in Q3.13 radians to sine and cosine in Q30.
// Depends on ezr_pkg; every register stage advances only while en is high.
module ezr_sincos #(
	parameter int STAGES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic signed [ezr_pkg::ANGLE_W-1:0] angle,
	output logic signed [ezr_pkg::XW-1:0]      sin_val,
	output logic signed [ezr_pkg::XW-1:0]      cos_val
);

	localparam int SH_R = (ezr_pkg::FRAC_W > 12) ? ezr_pkg::FRAC_W - 12 : 0;
	localparam int SH_L = (ezr_pkg::FRAC_W > 12) ? 0 : 12 - ezr_pkg::FRAC_W;

	logic signed [63:0]              prod;
	logic signed [63:0]              bias;
	logic signed [63:0]              scaled;
	logic signed [ezr_pkg::ZW-1:0]   z_s1;
	logic signed [ezr_pkg::ZW-1:0]   z_s2;
	logic                            flip_s2;
	logic signed [ezr_pkg::XW-1:0]   cx_s [1:STAGES];
	logic signed [ezr_pkg::XW-1:0]   cy_s [1:STAGES];
	logic signed [ezr_pkg::ZW-1:0]   cz_s [1:STAGES];
	logic                            fl_s [1:STAGES];

	assign prod   = 64'(angle) * ezr_pkg::FIVE_POW_12;
	assign bias   = prod[63] ? ((64'sd1 <<< SH_R) - 64'sd1) : 64'sd0;
	assign scaled = ((prod + bias) >>> SH_R) <<< SH_L;

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1 <= scaled[ezr_pkg::ZW-1:0];
			if (z_s1 > ezr_pkg::HALF_PI_PICO) begin
				z_s2    <= z_s1 - ezr_pkg::PI_PICO;
				flip_s2 <= 1'b1;
			end else if (z_s1 < -ezr_pkg::HALF_PI_PICO) begin
				z_s2    <= z_s1 + ezr_pkg::PI_PICO;
				flip_s2 <= 1'b1;
			end else begin
				z_s2    <= z_s1;
				flip_s2 <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic signed [ezr_pkg::XW-1:0] xin;
		logic signed [ezr_pkg::XW-1:0] yin;
		logic signed [ezr_pkg::ZW-1:0] zin;
		logic                          fin;
		if (i == 0) begin : g_first
			assign xin = ezr_pkg::CORDIC_GAIN;
			assign yin = '0;
			assign zin = z_s2;
			assign fin = flip_s2;
		end else begin : g_next
			assign xin = cx_s[i];
			assign yin = cy_s[i];
			assign zin = cz_s[i];
			assign fin = fl_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (zin >= 0) begin
					cx_s[i+1] <= xin - (yin >>> i);
					cy_s[i+1] <= yin + (xin >>> i);
					cz_s[i+1] <= zin - ezr_pkg::ATAN_PICO[i];
				end else begin
					cx_s[i+1] <= xin + (yin >>> i);
					cy_s[i+1] <= yin - (xin >>> i);
					cz_s[i+1] <= zin + ezr_pkg::ATAN_PICO[i];
				end
				fl_s[i+1] <= fin;
			end
		end
	end

	// fold back the half turn removed at the input
	always_ff @(posedge clk) begin
		if (en) begin
			sin_val <= fl_s[STAGES] ? -cy_s[STAGES] : cy_s[STAGES];
			cos_val <= fl_s[STAGES] ? -cx_s[STAGES] : cx_s[STAGES];
		end
	end

endmodule

[hdl/euler_zyx_to_rotation_matrix_top.sv]
// Euler Z-Y-X angles to 3x3 rotation matrix, top level.
// Depends on ezr_pkg and ezr_sincos (three instances, one per angle).
//
// Input channel in_valid/in_stall/in_data carries one angle triple, Q3.13 radians.
// Output channel out_valid/out_stall/out_data carries the nine Q1.14 entries,
// saturated to plus or minus one.
// APB register 0 (decoded on paddr[2] = 0), bit 0: angle order; 0 = yaw,pitch,roll, 1 = roll,pitch,yaw.
// Write it only while no transfer is in flight.
// The pipeline registers the scaled angle, the angle folded into a quarter turn, each CORDIC
// iteration and the undone fold, then the results of multiply, multiply, sum and round.
// Throughput is one triple per cycle while the output is not stalled; every stage holds one triple.
// Reset clears all valid bits and the angle order; payload registers are not reset.
// When the receiver stalls a held result, the whole pipeline holds and in_stall rises
// in the same cycle; nothing is lost or repeated.
module euler_zyx_to_rotation_matrix_top #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  ezr_pkg::angles_t in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output ezr_pkg::matrix_t out_data,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int LAT = CORDIC_STAGES + 7;
	localparam int XW  = ezr_pkg::XW;
	localparam int PW  = ezr_pkg::PW;

	logic                            order_q;
	logic                            en;
	logic [LAT-1:0]                  vld_q;
	logic signed [ezr_pkg::ANGLE_W-1:0] yaw_in, roll_in;
	logic signed [XW-1:0] sa, ca, sb, cb, sg, cg;

	logic signed [PW-1:0] p_sbsg_s1, p_sbcg_s1;
	logic signed [PW-1:0] q00_s1, q10_s1, q20_s1, q21_s1, q22_s1;
	logic signed [XW-1:0] sa_s1, ca_s1, sg_s1, cg_s1;

	logic signed [XW-1:0] sbsg, sbcg;
	logic signed [PW-1:0] a01_s2, b01_s2, a02_s2, b02_s2;
	logic signed [PW-1:0] a11_s2, b11_s2, a12_s2, b12_s2;
	logic signed [PW-1:0] q00_s2, q10_s2, q20_s2, q21_s2, q22_s2;

	logic signed [PW-1:0] q00_s3, q01_s3, q02_s3, q10_s3, q11_s3, q12_s3;
	logic signed [PW-1:0] q20_s3, q21_s3, q22_s3;

	assign pready = 1'b1;
	assign prdata = {31'd0, order_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr[2] == ezr_pkg::paddr_order)) begin
			order_q <= pwdata[0];
		end
	end

	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	assign yaw_in  = order_q ? in_data.angle_third : in_data.angle_first;
	assign roll_in = order_q ? in_data.angle_first : in_data.angle_third;

	ezr_sincos #(.STAGES(CORDIC_STAGES)) u_yaw (
		.clk(clk), .arst_n(arst_n), .en(en), .angle(yaw_in), .sin_val(sa), .cos_val(ca)
	);
	ezr_sincos #(.STAGES(CORDIC_STAGES)) u_pitch (
		.clk(clk), .arst_n(arst_n), .en(en), .angle(in_data.angle_second),
		.sin_val(sb), .cos_val(cb)
	);
	ezr_sincos #(.STAGES(CORDIC_STAGES)) u_roll (
		.clk(clk), .arst_n(arst_n), .en(en), .angle(roll_in), .sin_val(sg), .cos_val(cg)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			p_sbsg_s1 <= PW'(sb) * PW'(sg);
			p_sbcg_s1 <= PW'(sb) * PW'(cg);
			q00_s1    <= PW'(ca) * PW'(cb);
			q10_s1    <= PW'(sa) * PW'(cb);
			q21_s1    <= PW'(cb) * PW'(sg);
			q22_s1    <= PW'(cb) * PW'(cg);
			q20_s1    <= -(PW'(sb) <<< 30);
			sa_s1     <= sa;
			ca_s1     <= ca;
			sg_s1     <= sg;
			cg_s1     <= cg;
		end
	end

	assign sbsg = ezr_pkg::round_q30(p_sbsg_s1);
	assign sbcg = ezr_pkg::round_q30(p_sbcg_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			a01_s2 <= PW'(ca_s1) * PW'(sbsg);
			b01_s2 <= PW'(sa_s1) * PW'(cg_s1);
			a02_s2 <= PW'(ca_s1) * PW'(sbcg);
			b02_s2 <= PW'(sa_s1) * PW'(sg_s1);
			a11_s2 <= PW'(sa_s1) * PW'(sbsg);
			b11_s2 <= PW'(ca_s1) * PW'(cg_s1);
			a12_s2 <= PW'(sa_s1) * PW'(sbcg);
			b12_s2 <= PW'(ca_s1) * PW'(sg_s1);
			q00_s2 <= q00_s1;
			q10_s2 <= q10_s1;
			q20_s2 <= q20_s1;
			q21_s2 <= q21_s1;
			q22_s2 <= q22_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q01_s3 <= a01_s2 - b01_s2;
			q02_s3 <= a02_s2 + b02_s2;
			q11_s3 <= a11_s2 + b11_s2;
			q12_s3 <= a12_s2 - b12_s2;
			q00_s3 <= q00_s2;
			q10_s3 <= q10_s2;
			q20_s3 <= q20_s2;
			q21_s3 <= q21_s2;
			q22_s3 <= q22_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.m00 <= ezr_pkg::entry_q14(q00_s3);
			out_data.m01 <= ezr_pkg::entry_q14(q01_s3);
			out_data.m02 <= ezr_pkg::entry_q14(q02_s3);
			out_data.m10 <= ezr_pkg::entry_q14(q10_s3);
			out_data.m11 <= ezr_pkg::entry_q14(q11_s3);
			out_data.m12 <= ezr_pkg::entry_q14(q12_s3);
			out_data.m20 <= ezr_pkg::entry_q14(q20_s3);
			out_data.m21 <= ezr_pkg::entry_q14(q21_s3);
			out_data.m22 <= ezr_pkg::entry_q14(q22_s3);
		end
	end

endmodule

[hdl/ezr_checker.sv]
// Port-level checks for euler_zyx_to_rotation_matrix_top, attached by bind.
// Depends on ezr_pkg for the payload types.
module ezr_port_checks (
	input logic             clk,
	input logic             arst_n,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input ezr_pkg::matrix_t out_data,
	input logic             psel,
	input logic             penable,
	input logic             pwrite,
	input logic [2:0]       paddr,
	input logic [31:0]      pwdata,
	input logic [31:0]      prdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("held transfer changed");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output held");

	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.m00 <= 16'sd16384) && (out_data.m00 >= -16'sd16384)
			&& (out_data.m20 <= 16'sd16384) && (out_data.m20 >= -16'sd16384)
			&& (out_data.m22 <= 16'sd16384) && (out_data.m22 >= -16'sd16384))
		else $error("entry out of range");

	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr[2] == ezr_pkg::paddr_order)
			|=> prdata[0] == $past(pwdata[0]))
		else $error("register readback mismatch");

endmodule

bind euler_zyx_to_rotation_matrix_top ezr_port_checks u_ezr_port_checks (.*);
